>>> sv/quadratic_root_solver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic root solver
// Each macro expands to a labeled concurrent assertion, or to nothing when
// NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define QRS_ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define QRS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define QRS_ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg)
`define QRS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif

`endif

>>> sv/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, status codes and pipeline transaction types of the root solver.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int DEN_W     = WORD_BITS + 1;
  localparam int DISC_W    = 2 * WORD_BITS + 2;
  localparam int ROOT_W    = DISC_W / 2;
  localparam int SQ_REM_W  = ROOT_W + 3;
  localparam int NUM_W     = ROOT_W + 2;
  localparam int NMAG_W    = NUM_W - 1;
  localparam int DVD_W     = NMAG_W + FRAC_BITS;
  localparam int LANES     = 2;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_AZERO = 2'd1,
    STATUS_SAT   = 2'd2
  } status_t;

  typedef struct packed {
    logic                        valid;
    logic                        azero;
    logic                        aneg;
    logic                        dneg;
    logic signed [WORD_BITS:0]   negb;
    logic [DEN_W-1:0]            den;
  } side_t;

  typedef struct packed {
    logic [DISC_W-1:0]   rad;
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
    side_t               side;
  } sqrt_t;

  typedef struct packed {
    logic [DVD_W-1:0] num;
    logic [DEN_W-1:0] rem;
    logic             neg;
  } lane_t;

  typedef struct packed {
    logic                    valid;
    logic                    azero;
    logic                    dneg;
    logic [DEN_W-1:0]        den;
    lane_t [LANES-1:0]       lane;
  } div_t;

endpackage

`default_nettype wire

>>> sv/qrs_if.sv
// ----------------------------------------------------------------------------
// qrs_if
// Coefficient and root channels of the root solver, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface qrs_coef_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [qrs_pkg::WORD_BITS-1:0]   coef_a;
  logic signed [qrs_pkg::WORD_BITS-1:0]   coef_b;
  logic signed [qrs_pkg::WORD_BITS-1:0]   coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [qrs_pkg::WORD_BITS-1:0]   root_first_real;
  logic signed [qrs_pkg::WORD_BITS-1:0]   root_second_real;
  logic signed [qrs_pkg::WORD_BITS-1:0]   imag_magnitude;
  logic                                   roots_complex;
  qrs_pkg::status_t                       status;

  modport source (output valid, root_first_real, root_second_real, imag_magnitude,
                  roots_complex, status, input ready);
  modport sink (input valid, root_first_real, root_second_real, imag_magnitude,
                roots_complex, status, output ready);
endinterface

`default_nettype wire

>>> sv/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit of the integer square root: brings in two radicand bits and
// decides one root bit, then registers the partial result.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire qrs_pkg::sqrt_t d,
  output qrs_pkg::sqrt_t      q
);

  logic [qrs_pkg::SQ_REM_W-1:0] t;
  logic [qrs_pkg::SQ_REM_W-1:0] trial;
  logic                         ge;
  qrs_pkg::sqrt_t               q_next;

  assign t     = {d.rem[qrs_pkg::SQ_REM_W-3:0], d.rad[qrs_pkg::DISC_W-1 -: 2]};
  assign trial = {{(qrs_pkg::SQ_REM_W-qrs_pkg::ROOT_W-2){1'b0}}, d.root, 2'b01};
  assign ge    = (t >= trial);

  always_comb begin
    q_next      = d;
    q_next.rad  = {d.rad[qrs_pkg::DISC_W-3:0], 2'b00};
    q_next.rem  = ge ? (t - trial) : t;
    q_next.root = {d.root[qrs_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.side.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell
// One restoring division step for both quotient lanes: shift in one dividend
// bit, subtract the divisor where it fits, register the quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire qrs_pkg::div_t d,
  output qrs_pkg::div_t      q
);

  logic [qrs_pkg::DEN_W:0] t;
  logic [qrs_pkg::DEN_W:0] diff;
  logic                    ge;
  qrs_pkg::div_t           q_next;

  always_comb begin
    q_next = d;
    t      = '0;
    diff   = '0;
    ge     = 1'b0;
    for (int l = 0; l < qrs_pkg::LANES; l++) begin
      t    = {d.lane[l].rem, d.lane[l].num[qrs_pkg::DVD_W-1]};
      diff = t - {1'b0, d.den};
      ge   = (t >= {1'b0, d.den});
      q_next.lane[l].rem = ge ? diff[qrs_pkg::DEN_W-1:0] : t[qrs_pkg::DEN_W-1:0];
      q_next.lane[l].num = {d.lane[l].num[qrs_pkg::DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Pipelined solver of a*x^2 + b*x + c = 0 in signed Q16.16: exact
// discriminant, digit-per-cell square root, bit-per-cell division.
// ----------------------------------------------------------------------------
//  channel | role   | payload
//  coef    | sink   | coef_a, coef_b, coef_c
//  roots   | source | root_first_real, root_second_real, imag_magnitude,
//          |        | roots_complex, status
//
//  One transaction per cycle while the pipeline advances; at Q16.16 there are
//  33 square root cells and 50 divider cells.
//  The whole pipeline advances while the output register is empty or taken.
//  Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadratic_root_solver_assert.svh"

module quadratic_root_solver (
  input wire logic   clk,
  input wire logic   rst,
  qrs_coef_if.sink   coef,
  qrs_root_if.source roots
);

  localparam int W = qrs_pkg::WORD_BITS;

  logic en;
  assign en         = !roots.valid || roots.ready;
  assign coef.ready = en;

  // multiply stage
  logic [W-1:0]              am;
  logic [W-1:0]              bm;
  logic [W-1:0]              cm;
  logic signed [W:0]         bx;
  logic [2*W-1:0]            bb_w;
  logic [2*W-1:0]            ac_w;

  assign am   = coef.coef_a[W-1] ? (~coef.coef_a + 1'b1) : coef.coef_a;
  assign bm   = coef.coef_b[W-1] ? (~coef.coef_b + 1'b1) : coef.coef_b;
  assign cm   = coef.coef_c[W-1] ? (~coef.coef_c + 1'b1) : coef.coef_c;
  assign bx   = {coef.coef_b[W-1], coef.coef_b};
  assign bb_w = bm * bm;
  assign ac_w = am * cm;

  logic                       s1_valid;
  logic                       s1_azero;
  logic                       s1_aneg;
  logic                       s1_diff;
  logic signed [W:0]          s1_negb;
  logic [qrs_pkg::DEN_W-1:0]  s1_den;
  logic [2*W-1:0]             s1_bb;
  logic [2*W-1:0]             s1_ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= coef.valid;
      s1_azero <= (coef.coef_a == '0);
      s1_aneg  <= coef.coef_a[W-1];
      s1_diff  <= coef.coef_a[W-1] != coef.coef_c[W-1];
      s1_negb  <= -bx;
      s1_den   <= {am, 1'b0};
      s1_bb    <= bb_w;
      s1_ac    <= ac_w;
    end
  end

  // discriminant stage
  logic [qrs_pkg::DISC_W-1:0] bbx;
  logic [qrs_pkg::DISC_W-1:0] ac4;
  qrs_pkg::sqrt_t             s2_next;

  assign bbx = {2'b00, s1_bb};
  assign ac4 = {s1_ac, 2'b00};

  always_comb begin
    s2_next            = '0;
    s2_next.side.valid = s1_valid;
    s2_next.side.azero = s1_azero;
    s2_next.side.aneg  = s1_aneg;
    s2_next.side.negb  = s1_negb;
    s2_next.side.den   = s1_den;
    if (s1_diff) begin
      s2_next.rad = bbx + ac4;
    end else if (bbx < ac4) begin
      s2_next.rad       = ac4 - bbx;
      s2_next.side.dneg = 1'b1;
    end else begin
      s2_next.rad = bbx - ac4;
    end
  end

  qrs_pkg::sqrt_t sq [qrs_pkg::ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].side.valid <= 1'b0;
    end else if (en) begin
      sq[0] <= s2_next;
    end
  end

  for (genvar k = 0; k < qrs_pkg::ROOT_W; k++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (sq[k]),
      .q   (sq[k+1])
    );
  end

  // numerator stage
  qrs_pkg::sqrt_t                   sqo;
  logic signed [qrs_pkg::NUM_W-1:0] sx;
  logic signed [qrs_pkg::NUM_W-1:0] nbx;
  logic signed [qrs_pkg::NUM_W-1:0] na;
  logic signed [qrs_pkg::NUM_W-1:0] nb2;
  logic [qrs_pkg::NUM_W-1:0]        ma;
  logic [qrs_pkg::NUM_W-1:0]        mb;
  qrs_pkg::div_t                    s3_next;

  assign sqo = sq[qrs_pkg::ROOT_W];
  assign sx  = {2'b00, sqo.root};
  assign nbx = {{(qrs_pkg::NUM_W-W-1){sqo.side.negb[W]}}, sqo.side.negb};
  assign na  = sqo.side.dneg ? nbx : nbx + sx;
  assign nb2 = sqo.side.dneg ? sx : nbx - sx;
  assign ma  = na[qrs_pkg::NUM_W-1] ? -na : na;
  assign mb  = nb2[qrs_pkg::NUM_W-1] ? -nb2 : nb2;

  always_comb begin
    s3_next              = '0;
    s3_next.valid        = sqo.side.valid;
    s3_next.azero        = sqo.side.azero;
    s3_next.dneg         = sqo.side.dneg;
    s3_next.den          = sqo.side.den;
    s3_next.lane[0].num  = {ma[qrs_pkg::NMAG_W-1:0], {qrs_pkg::FRAC_BITS{1'b0}}};
    s3_next.lane[0].neg  = (na[qrs_pkg::NUM_W-1] != sqo.side.aneg) && (na != '0);
    s3_next.lane[1].num  = {mb[qrs_pkg::NMAG_W-1:0], {qrs_pkg::FRAC_BITS{1'b0}}};
    s3_next.lane[1].neg  = !sqo.side.dneg && (nb2[qrs_pkg::NUM_W-1] != sqo.side.aneg)
                           && (nb2 != '0);
  end

  qrs_pkg::div_t dv [qrs_pkg::DVD_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (en) begin
      dv[0] <= s3_next;
    end
  end

  for (genvar k = 0; k < qrs_pkg::DVD_W; k++) begin : g_div
    qrs_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (dv[k]),
      .q   (dv[k+1])
    );
  end

  // saturate and output register
  qrs_pkg::div_t dvo;
  logic [W-1:0]  val [qrs_pkg::LANES];
  logic          sat [qrs_pkg::LANES];
  logic [W-1:0]  lo;
  logic          hi;

  assign dvo = dv[qrs_pkg::DVD_W];

  always_comb begin
    lo = '0;
    hi = 1'b0;
    for (int l = 0; l < qrs_pkg::LANES; l++) begin
      lo = dvo.lane[l].num[W-1:0];
      hi = |dvo.lane[l].num[qrs_pkg::DVD_W-1:W];
      if (dvo.lane[l].neg) begin
        sat[l] = hi || (lo[W-1] && (lo[W-2:0] != '0));
        val[l] = sat[l] ? {1'b1, {(W-1){1'b0}}} : (~lo + 1'b1);
      end else begin
        sat[l] = hi || lo[W-1];
        val[l] = sat[l] ? {1'b0, {(W-1){1'b1}}} : lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roots.valid <= 1'b0;
    end else if (en) begin
      roots.valid <= dvo.valid;
      if (dvo.azero) begin
        roots.root_first_real  <= '0;
        roots.root_second_real <= '0;
        roots.imag_magnitude   <= '0;
        roots.roots_complex    <= 1'b0;
        roots.status           <= qrs_pkg::STATUS_AZERO;
      end else begin
        roots.root_first_real  <= val[0];
        roots.root_second_real <= dvo.dneg ? val[0] : val[1];
        roots.imag_magnitude   <= dvo.dneg ? val[1] : '0;
        roots.roots_complex    <= dvo.dneg;
        roots.status           <= (sat[0] || sat[1]) ? qrs_pkg::STATUS_SAT
                                                     : qrs_pkg::STATUS_OK;
      end
    end
  end

  `QRS_ASSERT_IMPLY(a_complex_same_real, clk, rst, roots.valid && roots.roots_complex, roots.root_first_real == roots.root_second_real, "complex roots with differing real parts")
  `QRS_ASSERT_IMPLY(a_real_no_imag, clk, rst, roots.valid && !roots.roots_complex, roots.imag_magnitude == '0, "real roots with nonzero imaginary part")
  `QRS_ASSERT_IMPLY(a_azero_clear, clk, rst, roots.valid && roots.status == qrs_pkg::STATUS_AZERO, !roots.roots_complex && roots.root_first_real == '0, "zero leading coefficient with nonzero result")
  `QRS_ASSERT_NEXT(a_stall_hold, clk, rst, !en && dvo.valid, dv[qrs_pkg::DVD_W].valid, "divider output lost during stall")

endmodule

`default_nettype wire

>>> tb/quadratic_root_solver_checker.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_checker
// Watches the coefficient and root channels, predicts the roots of every
// accepted coefficient transaction and compares them in order with the
// roots that come out.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver_checker
  import qrs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  qrs_coef_if       coef,
  qrs_root_if       roots,
  output int        mismatches,
  output int        outstanding
);

  typedef struct {
    logic signed [WORD_BITS-1:0] first_real;
    logic signed [WORD_BITS-1:0] second_real;
    logic signed [WORD_BITS-1:0] imag;
    logic                        is_complex;
    status_t                     status;
  } root_set_t;

  root_set_t expected_roots[$];

  function automatic logic [WORD_BITS-1:0] scaled_quotient(input logic neg,
      input logic [63:0] nmag, input logic [63:0] den, inout logic sat);
    logic [63:0] q;
    q = (nmag << FRAC_BITS) / den;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return WORD_BITS'(-q);
    end
    if (q > 64'h7fff_ffff) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    return WORD_BITS'(q);
  endfunction

  function automatic root_set_t solve_quadratic(input logic signed [WORD_BITS-1:0] a,
      input logic signed [WORD_BITS-1:0] b, input logic signed [WORD_BITS-1:0] c);
    root_set_t r;
    longint sa, sb, sc, n1, n2;
    logic [67:0] am, bm, cm, bb, ac4, disc, cand, root;
    logic dneg, sat, aneg;
    sa = a;
    sb = b;
    sc = c;
    r.first_real = '0;
    r.second_real = '0;
    r.imag = '0;
    r.is_complex = 1'b0;
    r.status = STATUS_AZERO;
    if (sa == 0) return r;
    am = sa < 0 ? -sa : sa;
    bm = sb < 0 ? -sb : sb;
    cm = sc < 0 ? -sc : sc;
    aneg = sa < 0;
    bb = bm * bm;
    ac4 = 4 * am * cm;
    dneg = 1'b0;
    sat = 1'b0;
    if ((sa < 0) != (sc < 0)) disc = bb + ac4;
    else if (bb < ac4) begin
      disc = ac4 - bb;
      dneg = 1'b1;
    end else disc = bb - ac4;
    root = '0;
    for (int i = 33; i >= 0; i--) begin
      cand = root | (68'd1 << i);
      if (cand * cand <= disc) root = cand;
    end
    if (dneg) begin
      r.first_real = scaled_quotient((sb > 0) != aneg, bm[63:0], 2 * am[63:0], sat);
      r.second_real = r.first_real;
      r.imag = scaled_quotient(1'b0, root[63:0], 2 * am[63:0], sat);
    end else begin
      n1 = -sb + longint'(root[63:0]);
      n2 = -sb - longint'(root[63:0]);
      r.first_real = scaled_quotient((n1 < 0) != aneg && n1 != 0,
                                     n1 < 0 ? -n1 : n1, 2 * am[63:0], sat);
      r.second_real = scaled_quotient((n2 < 0) != aneg && n2 != 0,
                                      n2 < 0 ? -n2 : n2, 2 * am[63:0], sat);
    end
    r.is_complex = dneg;
    r.status = sat ? STATUS_SAT : STATUS_OK;
    return r;
  endfunction

  assign outstanding = expected_roots.size();

  initial mismatches = 0;

  always @(posedge clk) begin
    root_set_t want;
    if (!rst) begin
      if (coef.valid && coef.ready)
        expected_roots.push_back(solve_quadratic(coef.coef_a, coef.coef_b, coef.coef_c));
      if (roots.valid && roots.ready) begin
        if (expected_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected roots transaction");
        end else begin
          want = expected_roots.pop_front();
          if (roots.root_first_real !== want.first_real ||
              roots.root_second_real !== want.second_real ||
              roots.imag_magnitude !== want.imag ||
              roots.roots_complex !== want.is_complex || roots.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("roots mismatch: expected %h %h %h %b %s, got %h %h %h %b %h",
                       want.first_real, want.second_real, want.imag, want.is_complex,
                       want.status.name(), roots.root_first_real, roots.root_second_real,
                       roots.imag_magnitude, roots.roots_complex, roots.status);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/quadratic_root_solver_test.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_test
// Drives directed and random coefficient triples into the root solver under
// changing idle patterns on both channels and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver_test;
  import qrs_pkg::*;

  localparam int LATENCY_WAIT = 200;
  localparam int STALL_LIMIT  = 5000;

  logic clk;
  logic rst;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   mismatches;
  int   outstanding;
  int   quiet_cycles;

  qrs_coef_if coef ();
  qrs_root_if roots ();

  quadratic_root_solver i_dut (.clk(clk), .rst(rst), .coef(coef), .roots(roots));

  quadratic_root_solver_checker i_checker (
    .clk(clk), .rst(rst), .coef(coef), .roots(roots),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    roots.ready = 1'b0;
    rx_idle_pct = 0;
  end

  always @(posedge clk) begin
    roots.ready <= $urandom_range(99) >= rx_idle_pct;
  end

  always @(posedge clk) begin
    if (rst || (coef.valid && coef.ready) || (roots.valid && roots.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("quadratic_root_solver regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_coef(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    logic rdy;
    while ($urandom_range(99) < tx_idle_pct) begin
      coef.valid <= 1'b0;
      @(posedge clk);
    end
    coef.valid <= 1'b1;
    coef.coef_a <= a;
    coef.coef_b <= b;
    coef.coef_c <= c;
    do begin
      @(negedge clk);
      rdy = coef.ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  function automatic logic [31:0] rand_small();
    return 32'($signed($urandom_range(32'h3f_ffff)) - 32'sh20_0000);
  endfunction

  task automatic send_random();
    logic [31:0] a, b, c, r1, r2;
    case ($urandom_range(9))
      0, 1, 2: send_coef(rand_small(), rand_small(), rand_small());
      3: send_coef(rand_small(), $urandom, $urandom);
      4: send_coef($urandom, $urandom, $urandom);
      5: send_coef(rand_small(), rand_small(), 32'd0);
      6: send_coef($urandom_range(1) ? 32'h0001_0000 : 32'hffff_0000, rand_small(),
                   rand_small());
      7: begin
        r1 = rand_small();
        r2 = rand_small();
        a = 32'h0001_0000;
        b = -(r1 + r2);
        c = 32'((longint'($signed(r1)) * longint'($signed(r2))) >>> 16);
        send_coef(a, b, c);
      end
      8: send_coef($urandom_range(1) ? 32'd0 : $urandom, $urandom, $urandom);
      default: begin
        a = $urandom_range(7) + 1;
        send_coef($urandom_range(1) ? a : -a, $urandom, rand_small());
      end
    endcase
  endtask

  task automatic drain();
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    tx_idle_pct = 0;
    coef.valid = 1'b0;
    coef.coef_a = '0;
    coef.coef_b = '0;
    coef.coef_c = '0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_coef(32'h0000_0000, 32'h0001_0000, 32'h0002_0000);
    send_coef(32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_coef(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
    send_coef(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
    send_coef(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);
    send_coef(32'hffff_0000, 32'h0000_0000, 32'h0004_0000);
    send_coef(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_coef(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coef(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coef(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_coef(32'h0000_0001, 32'h7fff_ffff, 32'h0000_0000);
    send_coef(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_coef(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    send_coef(32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000);
    send_coef(32'h7fff_ffff, 32'h0000_0001, 32'h0000_0000);
    send_coef(32'h0002_0000, 32'h0001_0000, 32'h0003_0000);
    send_coef(32'hfffe_0000, 32'h0001_0000, 32'hfffd_0000);
    send_coef(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
    send_coef(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_coef(32'h0000_8000, 32'h0000_0000, 32'h8000_0000);

    tx_idle_pct = 32;
    rx_idle_pct = 80;
    repeat (380) send_random();
    tx_idle_pct = 80;
    rx_idle_pct = 32;
    repeat (380) send_random();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (390) send_random();
    coef.valid <= 1'b0;

    drain();
    repeat (LATENCY_WAIT) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("quadratic_root_solver regression: pass");
    end else begin
      $display("quadratic_root_solver regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+sv
sv/qrs_pkg.sv
sv/qrs_if.sv
sv/qrs_sqrt_cell.sv
sv/qrs_div_cell.sv
sv/quadratic_root_solver.sv
tb/quadratic_root_solver_checker.sv
tb/quadratic_root_solver_test.sv
